FILE: sv/alpwm_pkg.sv
// Shared types and constants for the alternating LED pulse driver.
package alpwm_pkg;

  localparam int unsigned THR_W      = 16;
  localparam int unsigned DUTY_W     = 6;
  localparam int unsigned ELAPSED_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // period * duty fits in this many bits
  localparam int unsigned PROD_W      = THR_W + DUTY_W;
  // floor(x / 100) = (x * RECIP) >> RECIP_SHIFT for every x below 2**PROD_W
  localparam int unsigned RECIP_SHIFT = PROD_W + 7;
  localparam int unsigned RECIP_W     = PROD_W + 1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);
  localparam int unsigned QPROD_W     = PROD_W + RECIP_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_DUTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IR_DUTY  = 2'd2;

  localparam logic [THR_W-1:0]  PERIOD_RST = 16'd1000;
  localparam logic [DUTY_W-1:0] DUTY_RST   = 6'd25;
  // thresholds that follow from the reset configuration
  localparam logic [THR_W-1:0]  RED_THR_RST = 16'd250;
  localparam logic [THR_W-1:0]  IR_THR_RST  = 16'd250;
  localparam logic [THR_W-1:0]  GAP_THR_RST = 16'd250;

  // cycles the threshold pipeline needs after a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  typedef enum logic [1:0] {
    PH_RED   = 2'd0,
    PH_GAP_A = 2'd1,
    PH_IR    = 2'd2,
    PH_GAP_B = 2'd3
  } phase_e;

  typedef struct packed {
    logic [THR_W-1:0]  period;
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] ir_duty;
  } cfg_t;

  typedef struct packed {
    logic [THR_W-1:0] red;
    logic [THR_W-1:0] ir;
    logic [THR_W-1:0] gap;
  } thr_t;

endpackage

FILE: sv/alpwm_if.sv
// Handshake channels for tick items and LED result items.
interface alpwm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] elapsed_ticks;

  modport source (output valid, output elapsed_ticks, input ready);
  modport sink   (input valid, input elapsed_ticks, output ready);
endinterface

interface alpwm_out_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       ir_on;
  logic [1:0] phase;

  modport source (output valid, output red_on, output ir_on, output phase, input ready);
  modport sink   (input valid, input red_on, input ir_on, input phase, output ready);
endinterface

FILE: sv/alpwm_thr.sv
// Phase threshold pipeline: on times and gap time from the configuration registers.
module alpwm_thr (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  alpwm_pkg::cfg_t    cfg_i,
  output alpwm_pkg::thr_t    thr_o
);
  import alpwm_pkg::*;

  logic [PROD_W-1:0]  red_prod_q, ir_prod_q;
  logic [THR_W-1:0]   period_q, period2_q;
  logic [QPROD_W-1:0] red_q_wide, ir_q_wide;
  logic [THR_W-1:0]   red_t_q, ir_t_q;
  logic [THR_W:0]     used;
  logic [THR_W-1:0]   gap_d;
  thr_t               thr_q;

  // divide by 100 through a reciprocal multiply
  assign red_q_wide = QPROD_W'(red_prod_q) * QPROD_W'(RECIP);
  assign ir_q_wide  = QPROD_W'(ir_prod_q) * QPROD_W'(RECIP);

  assign used  = {1'b0, red_t_q} + {1'b0, ir_t_q};
  // clamp the gap to zero when the on times use up the period
  assign gap_d = (used >= {1'b0, period2_q}) ? '0 :
                 THR_W'((period2_q - used[THR_W-1:0]) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_prod_q <= PROD_W'(PERIOD_RST) * PROD_W'(DUTY_RST);
      ir_prod_q  <= PROD_W'(PERIOD_RST) * PROD_W'(DUTY_RST);
      period_q   <= PERIOD_RST;
      period2_q  <= PERIOD_RST;
      red_t_q    <= RED_THR_RST;
      ir_t_q     <= IR_THR_RST;
      thr_q      <= '{red: RED_THR_RST, ir: IR_THR_RST, gap: GAP_THR_RST};
    end else begin
      red_prod_q <= PROD_W'(cfg_i.period) * PROD_W'(cfg_i.red_duty);
      ir_prod_q  <= PROD_W'(cfg_i.period) * PROD_W'(cfg_i.ir_duty);
      period_q   <= cfg_i.period;
      red_t_q    <= red_q_wide[RECIP_SHIFT +: THR_W];
      ir_t_q     <= ir_q_wide[RECIP_SHIFT +: THR_W];
      period2_q  <= period_q;
      thr_q      <= '{red: red_t_q, ir: ir_t_q, gap: gap_d};
    end
  end

  assign thr_o = thr_q;

endmodule

FILE: sv/alternating_led_pwm_dead_time_top.sv
// Top level of the alternating red / infrared LED pulse driver with dead time.
//
//   port        direction  item contents
//   ----------  ---------  -------------------------------------------
//   in_i        sink       elapsed_ticks (8 bit time units since last)
//   out_o       source     red_on, ir_on, phase (after the update)
//   cfg_*_i     write      period_ticks, red_duty, ir_duty by index
//
// One item per cycle when out_o is ready; items go from the input slot to the result register.
// The phase update is one saturating add and one compare against a registered threshold.
// Thresholds come from a three stage pipeline (multiply, divide by 100, gap), so in_i
// drops ready during a register write and until the new thresholds have settled.
// Reset gives the red-on phase, a zero counter and period 1000 with both duties at 25.
// A stalled out_o holds its item; in_i then accepts only while the input slot is empty.
module alternating_led_pwm_dead_time_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  alpwm_in_if.sink                            in_i,
  alpwm_out_if.source                         out_o,
  input  logic                                cfg_we_i,
  input  logic [alpwm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [alpwm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import alpwm_pkg::*;

  localparam int unsigned CMP_W = ((COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W) + 1;

  // configuration registers
  cfg_t cfg_q;
  logic [1:0] settle_q;
  thr_t thr;

  // input slot
  logic                 in_vld_q;
  logic [ELAPSED_W-1:0] in_elapsed_q;

  // block state
  phase_e                 phase_q;
  logic [COUNT_WIDTH-1:0] tip_q;

  // result register
  logic   out_vld_q;
  phase_e out_phase_q;

  logic                   advance;
  logic                   in_ready;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat;
  logic [THR_W-1:0]       thr_sel;
  logic                   hit;
  phase_e                 phase_d;
  logic [COUNT_WIDTH-1:0] tip_d;

  alpwm_thr u_thr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .thr_o  (thr)
  );

  // hold off new items while thresholds settle after a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= '{period: PERIOD_RST, red_duty: DUTY_RST, ir_duty: DUTY_RST};
      settle_q <= '0;
    end else begin
      if (cfg_we_i) begin
        settle_q <= SETTLE_CYCLES;
        case (cfg_idx_i)
          CFG_PERIOD:   cfg_q.period   <= cfg_data_i;
          CFG_RED_DUTY: cfg_q.red_duty <= cfg_data_i[DUTY_W-1:0];
          CFG_IR_DUTY:  cfg_q.ir_duty  <= cfg_data_i[DUTY_W-1:0];
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  // process the held item whenever the result register is free or draining
  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_ready = !cfg_we_i && (settle_q == '0) && (!in_vld_q || advance);
  assign in_i.ready = in_ready;

  // saturating add of elapsed time
  assign sum = {1'b0, tip_q} + (COUNT_WIDTH + 1)'(in_elapsed_q);
  assign sat = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];

  always_comb begin
    case (phase_q)
      PH_RED:  thr_sel = thr.red;
      PH_IR:   thr_sel = thr.ir;
      default: thr_sel = thr.gap;
    endcase
  end

  assign hit = CMP_W'(sat) >= CMP_W'(thr_sel);

  always_comb begin
    phase_d = phase_q;
    tip_d   = sat;
    if (hit) begin
      // advance around the ring and drop excess time
      phase_d = phase_e'(phase_q + 2'd1);
      tip_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      phase_q   <= PH_RED;
      tip_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_q <= in_i.valid;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        phase_q   <= phase_d;
        tip_q     <= tip_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_elapsed_q <= in_i.elapsed_ticks;
    end
    if (advance) begin
      out_phase_q <= phase_d;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.phase  = out_phase_q;
  assign out_o.red_on = (out_phase_q == PH_RED);
  assign out_o.ir_on  = (out_phase_q == PH_IR);

endmodule
